// File: rtl/dde_pkg.sv
package dde_pkg;

    localparam int unsigned VALUE_W = 14;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned CURSOR_W = 2;
    localparam int unsigned COLUMN_W = 7;
    localparam int unsigned COUNT_W = 3;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 14;
    localparam int unsigned REM_W = 10;

    localparam logic [VALUE_W-1:0] VALUE_WRAP = 14'd10000;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    localparam logic [VALUE_W-1:0] MIN_VALUE_RST = 14'd0;
    localparam logic [VALUE_W-1:0] MAX_VALUE_RST = 14'd9999;
    localparam logic [COUNT_W-1:0] DIGIT_COUNT_RST = 3'd4;
    localparam logic [CURSOR_W-1:0] DOT_POSITION_RST = 2'd0;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MIN_VALUE    = 2'd0,
        CFG_MAX_VALUE    = 2'd1,
        CFG_DIGIT_COUNT  = 2'd2,
        CFG_DOT_POSITION = 2'd3
    } t_cfg_addr;

    typedef enum logic [1:0] {
        KIND_LOAD_MIN   = 2'd0,
        KIND_LOAD_VALUE = 2'd1,
        KIND_ADVANCE    = 2'd2,
        KIND_STEP       = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic                 direction;
        logic [VALUE_W-1:0]   load_value;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0]   current_value;
        logic [DIGIT_W-1:0]   digit_ones;
        logic [DIGIT_W-1:0]   digit_tens;
        logic [DIGIT_W-1:0]   digit_hundreds;
        logic [DIGIT_W-1:0]   digit_thousands;
        logic [CURSOR_W-1:0]  cursor;
        logic [COLUMN_W-1:0]  cursor_column;
        logic                 rejected;
    } t_out_item;

    // live configuration, register file to front and edit stages
    typedef struct packed {
        logic [VALUE_W-1:0]   min_value;
        logic [VALUE_W-1:0]   max_value;
        logic [COUNT_W-1:0]   digit_count;
        logic [CURSOR_W-1:0]  dot_position;
    } t_cfg;

    // item after the front stage: load source already reduced mod 10000,
    // thousands digit split off
    typedef struct packed {
        t_kind                kind;
        logic                 direction;
        logic [VALUE_W-1:0]   value;
        logic [DIGIT_W-1:0]   thousands;
        logic [REM_W-1:0]     rem;
    } t_front;

    // quotient by 1000 of a 14-bit value (0..16), parallel compares
    function automatic logic [4:0] div1000(input logic [VALUE_W-1:0] v);
        logic [4:0] q;
        q = 5'd0;
        for (int k = 1; k <= 16; k++) begin
            if (v >= 14'(k * 1000)) q = 5'(k);
        end
        return q;
    endfunction

    function automatic logic [DIGIT_W-1:0] div100(input logic [REM_W-1:0] v);
        logic [DIGIT_W-1:0] q;
        q = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (v >= 10'(k * 100)) q = 4'(k);
        end
        return q;
    endfunction

    function automatic logic [DIGIT_W-1:0] div10(input logic [6:0] v);
        logic [DIGIT_W-1:0] q;
        q = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (v >= 7'(k * 10)) q = 4'(k);
        end
        return q;
    endfunction

    function automatic logic [VALUE_W-1:0] weight(input logic [CURSOR_W-1:0] pos);
        logic [VALUE_W-1:0] w;
        case (pos)
            2'd0:    w = 14'd1;
            2'd1:    w = 14'd10;
            2'd2:    w = 14'd100;
            default: w = 14'd1000;
        endcase
        return w;
    endfunction

    function automatic logic [VALUE_W-1:0] weight9(input logic [CURSOR_W-1:0] pos);
        logic [VALUE_W-1:0] w;
        case (pos)
            2'd0:    w = 14'd9;
            2'd1:    w = 14'd90;
            2'd2:    w = 14'd900;
            default: w = 14'd9000;
        endcase
        return w;
    endfunction

    // 73 - 11 per position, 11 more from the dot position on
    function automatic logic [COLUMN_W-1:0] column(input logic [CURSOR_W-1:0] pos,
                                                   input logic [CURSOR_W-1:0] dot);
        int col;
        col = 73 - 11 * int'(pos);
        if (pos >= dot) col = col - 11;
        return 7'(col);
    endfunction

endpackage

// File: rtl/dde_front.sv
module dde_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  dde_pkg::t_in_item         i_in_item,
    input  logic [dde_pkg::VALUE_W-1:0] i_min_value,
    input  logic                      i_take,
    output logic                      o_s1_valid,
    output dde_pkg::t_front           o_s1
);

    logic                            r_valid;
    dde_pkg::t_front                 r_s1;
    dde_pkg::t_front                 n_s1;
    logic [dde_pkg::VALUE_W-1:0]     w_src;
    logic [4:0]                      w_q;
    logic                            w_load;

    // stage is free when empty or its beat moves on this cycle
    assign o_in_stall = r_valid && !i_take;
    assign w_load     = !o_in_stall;

    always_comb begin
        w_src = (i_in_item.kind == dde_pkg::KIND_LOAD_MIN) ? i_min_value
                                                          : i_in_item.load_value;
        w_q = dde_pkg::div1000(w_src);
        n_s1.kind      = i_in_item.kind;
        n_s1.direction = i_in_item.direction;
        n_s1.value     = (w_src >= dde_pkg::VALUE_WRAP) ? w_src - dde_pkg::VALUE_WRAP
                                                        : w_src;
        n_s1.thousands = (w_q >= 5'd10) ? 4'(w_q - 5'd10) : w_q[3:0];
        n_s1.rem       = 10'(w_src - 14'(int'(w_q) * 1000));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_in_valid) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_valid = r_valid;
    assign o_s1       = r_s1;

endmodule

// File: rtl/dde_core.sv
module dde_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s1_valid,
    input  dde_pkg::t_front    i_s1,
    input  dde_pkg::t_cfg      i_cfg,
    output logic               o_take,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dde_pkg::t_out_item o_out_item
);

    logic [dde_pkg::DIGIT_W-1:0]  r_digits [4];
    logic [dde_pkg::DIGIT_W-1:0]  n_digits [4];
    logic [dde_pkg::VALUE_W-1:0]  r_value;
    logic [dde_pkg::VALUE_W-1:0]  n_value;
    logic [dde_pkg::CURSOR_W-1:0] r_cursor;
    logic [dde_pkg::CURSOR_W-1:0] n_cursor;
    logic                         r_out_valid;
    dde_pkg::t_out_item           r_out;

    logic                         w_out_free;
    logic                         w_rejected;
    logic [dde_pkg::DIGIT_W-1:0]  w_digit;
    logic [dde_pkg::DIGIT_W-1:0]  w_new_digit;
    logic [dde_pkg::VALUE_W-1:0]  w_new_value;
    logic [dde_pkg::DIGIT_W-1:0]  w_hund;
    logic [6:0]                   w_rem100;
    logic [dde_pkg::DIGIT_W-1:0]  w_tens;
    logic [dde_pkg::DIGIT_W-1:0]  w_ones;
    logic [dde_pkg::COUNT_W-1:0]  w_next;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_take     = i_s1_valid && w_out_free;

    always_comb begin
        // low digits of a load
        w_hund   = dde_pkg::div100(i_s1.rem);
        w_rem100 = 7'(i_s1.rem - 10'(int'(w_hund) * 100));
        w_tens   = dde_pkg::div10(w_rem100);
        w_ones   = 4'(w_rem100 - 7'(int'(w_tens) * 10));

        w_digit     = r_digits[r_cursor];
        w_new_digit = w_digit;
        w_new_value = r_value;
        w_next      = {1'b0, r_cursor} + 3'd1;
        w_rejected  = 1'b0;

        n_digits = r_digits;
        n_value  = r_value;
        n_cursor = r_cursor;

        unique case (i_s1.kind) inside
            dde_pkg::KIND_LOAD_MIN, dde_pkg::KIND_LOAD_VALUE: begin
                n_digits[0] = w_ones;
                n_digits[1] = w_tens;
                n_digits[2] = w_hund;
                n_digits[3] = i_s1.thousands;
                n_value     = i_s1.value;
                n_cursor    = '0;
            end
            dde_pkg::KIND_ADVANCE: begin
                if (w_next >= i_cfg.digit_count || w_next > 3'd3) begin
                    n_cursor = '0;
                end else begin
                    n_cursor = w_next[1:0];
                end
            end
            dde_pkg::KIND_STEP: begin
                // digit wraps without carry; value moves by the digit weight, or by nine times it on a wrap
                if (i_s1.direction) begin
                    if (w_digit >= dde_pkg::DIGIT_MAX) begin
                        w_new_digit = '0;
                        w_new_value = r_value - dde_pkg::weight9(r_cursor);
                    end else begin
                        w_new_digit = w_digit + 4'd1;
                        w_new_value = r_value + dde_pkg::weight(r_cursor);
                    end
                end else begin
                    if (w_digit == '0) begin
                        w_new_digit = dde_pkg::DIGIT_MAX;
                        w_new_value = r_value + dde_pkg::weight9(r_cursor);
                    end else begin
                        w_new_digit = w_digit - 4'd1;
                        w_new_value = r_value - dde_pkg::weight(r_cursor);
                    end
                end
                if (w_new_value < i_cfg.min_value || w_new_value > i_cfg.max_value) begin
                    w_rejected = 1'b1;
                end else begin
                    n_digits[r_cursor] = w_new_digit;
                    n_value            = w_new_value;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digits    <= '{default: '0};
            r_value     <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_digits <= n_digits;
                r_value  <= n_value;
                r_cursor <= n_cursor;
            end
            if (w_out_free) begin
                r_out_valid <= i_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out.current_value   <= n_value;
            r_out.digit_ones      <= n_digits[0];
            r_out.digit_tens      <= n_digits[1];
            r_out.digit_hundreds  <= n_digits[2];
            r_out.digit_thousands <= n_digits[3];
            r_out.cursor          <= n_cursor;
            r_out.cursor_column   <= dde_pkg::column(n_cursor, i_cfg.dot_position);
            r_out.rejected        <= w_rejected;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// File: rtl/decimal_digit_entry_editor_core.sv
// Four-digit decimal entry editor.
//
// Input channel: i_in_valid / o_in_stall carry one edit beat (kind, direction,
// load_value). Output channel: o_out_valid / i_out_stall carry one result beat
// per input beat, in order: value, four digits, cursor, pixel column, reject.
// A beat moves at a clock edge with valid high and stall low.
//
// A beat accepted at the input passes the front register, then the result
// register. The front register splits off the thousands digit of a load,
// the edit register holds the digits and cursor and writes the result register.
// Throughput: one beat per cycle while the output is not stalled.
//
// Stalls: the result register holds while i_out_stall is high; the front
// register still takes one more beat, then o_in_stall rises.
//
// Reset (synchronous, active low): digits and cursor zero, pipeline empty,
// limits 0..9999, four digits, dot position 0. Config writes through
// i_cfg_we / i_cfg_addr / i_cfg_data belong only where the block is idle.
module decimal_digit_entry_editor_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  dde_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output dde_pkg::t_out_item             o_out_item,
    input  logic                           i_cfg_we,
    input  logic [dde_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [dde_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    dde_pkg::t_cfg   r_cfg;
    dde_pkg::t_front w_s1;
    logic            w_s1_valid;
    logic            w_take;

    // register file: each write replaces one register with the low bits of i_cfg_data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_value    <= dde_pkg::MIN_VALUE_RST;
            r_cfg.max_value    <= dde_pkg::MAX_VALUE_RST;
            r_cfg.digit_count  <= dde_pkg::DIGIT_COUNT_RST;
            r_cfg.dot_position <= dde_pkg::DOT_POSITION_RST;
        end else if (i_cfg_we) begin
            unique case (dde_pkg::t_cfg_addr'(i_cfg_addr))
                dde_pkg::CFG_MIN_VALUE:    r_cfg.min_value    <= i_cfg_data;
                dde_pkg::CFG_MAX_VALUE:    r_cfg.max_value    <= i_cfg_data;
                dde_pkg::CFG_DIGIT_COUNT:  r_cfg.digit_count  <= i_cfg_data[2:0];
                dde_pkg::CFG_DOT_POSITION: r_cfg.dot_position <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // front: load source select, mod 10000, thousands split
    dde_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_min_value (r_cfg.min_value),
        .i_take      (w_take),
        .o_s1_valid  (w_s1_valid),
        .o_s1        (w_s1)
    );

    // edit: digit state, cursor, range check, result register
    dde_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (w_s1_valid),
        .i_s1        (w_s1),
        .i_cfg       (r_cfg),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTH
    // input side backs up only when the result register is full and held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

    // shown value always matches the shown digits
    a_value_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.current_value ==
            14'(int'(o_out_item.digit_thousands) * 1000
              + int'(o_out_item.digit_hundreds) * 100
              + int'(o_out_item.digit_tens) * 10
              + int'(o_out_item.digit_ones))))
        else $error("current_value disagrees with digits");

    // every digit stays decimal
    a_digits_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.digit_ones <= dde_pkg::DIGIT_MAX
                      && o_out_item.digit_tens <= dde_pkg::DIGIT_MAX
                      && o_out_item.digit_hundreds <= dde_pkg::DIGIT_MAX
                      && o_out_item.digit_thousands <= dde_pkg::DIGIT_MAX))
        else $error("digit out of decimal range");

    // column follows the cursor and the dot position
    a_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_cfg_we) |-> (o_out_item.cursor_column ==
            dde_pkg::column(o_out_item.cursor, r_cfg.dot_position)))
        else $error("cursor_column does not match cursor");
`endif

endmodule
